>>> rtl/ffoa_pkg.sv
package ffoa_pkg;

    localparam int FREE_SEGMENTS_DEF = 16;
    localparam int BUFFER_IDS_DEF    = 64;
    localparam int OFFSET_BITS_DEF   = 40;
    localparam int ALIGN_W           = 21;
    localparam int CFG_ADDR_W        = 4;
    localparam int CFG_DATA_W        = 64;

    localparam logic [ALIGN_W-1:0] ALIGN_SMALL = ALIGN_W'(128);
    localparam logic [ALIGN_W-1:0] ALIGN_LARGE = ALIGN_W'(65536);
    localparam int                 LARGE_THRESHOLD = 32768;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ZERO_SIZE  = 3'd1,
        ST_NEVER      = 3'd2,
        ST_FREED      = 3'd3,
        ST_IDS_OUT    = 3'd4,
        ST_TABLE_FULL = 3'd5,
        ST_NO_CAP     = 3'd6,
        ST_BAD_ALIGN  = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_HIT,
        S_TAIL,
        S_TAIL_APPLY,
        S_RECORD,
        S_FREE_READ,
        S_FREE_SCAN,
        S_FREE_MERGE
    } state_t;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_LAST
    } idx_op_t;

    typedef enum logic [3:0] {
        SEG_NONE,
        SEG_SPLIT,
        SEG_SET_END_B,
        SEG_SET_BEGIN_BSZ,
        SEG_REMOVE,
        SEG_APPEND_GAP,
        SEG_F_BOTH,
        SEG_F_LEFT,
        SEG_F_RIGHT,
        SEG_F_INSERT
    } seg_op_t;

    typedef struct packed {
        logic    load;
        logic    calc;
        idx_op_t idx_op;
        logic    latch_b;
        logic    latch_tail;
        logic    latch_left;
        seg_op_t seg_op;
        logic    heap_upd;
        logic    record;
        logic    clr_live;
        logic    finish;
        logic    ok_alloc;
        status_t code;
    } cmd_t;

    typedef struct packed {
        logic is_free;
        logic zero;
        logic bad_al;
        logic ids_out;
        logic id_bad;
        logic dead;
        logic in_range;
        logic fit;
        logic scan_go;
        logic left_now;
        logic left_reg;
        logic right;
        logic gap;
        logic rest;
        logic full;
        logic tail;
        logic over_cap;
        logic moved;
    } flags_t;

endpackage

>>> rtl/ffoa_ctrl.sv
module ffoa_ctrl
    import ffoa_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  flags_t flags,
    output cmd_t   cmd,
    output logic   busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (flags.is_free)
                begin
                    state_next = (flags.id_bad || flags.dead) ? S_IDLE : S_FREE_READ;
                end
                else
                begin
                    state_next = (flags.zero || flags.bad_al || flags.ids_out) ? S_IDLE
                                                                               : S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (!flags.in_range)
                begin
                    state_next = S_TAIL;
                end
                else if (flags.fit)
                begin
                    state_next = S_HIT;
                end
            end
            S_HIT:
            begin
                state_next = (flags.gap && flags.rest && flags.full) ? S_IDLE : S_RECORD;
            end
            S_TAIL:
            begin
                state_next = S_TAIL_APPLY;
            end
            S_TAIL_APPLY:
            begin
                if (flags.over_cap)
                begin
                    state_next = S_IDLE;
                end
                else if (!flags.tail && flags.moved && flags.full)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RECORD;
                end
            end
            S_RECORD:
            begin
                state_next = S_IDLE;
            end
            S_FREE_READ:
            begin
                state_next = S_FREE_SCAN;
            end
            S_FREE_SCAN:
            begin
                if (!(flags.in_range && flags.scan_go))
                begin
                    state_next = S_FREE_MERGE;
                end
            end
            S_FREE_MERGE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.idx_op = IDX_HOLD;
        cmd.seg_op = SEG_NONE;
        cmd.code   = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_CHECK:
            begin
                cmd.calc   = 1'b1;
                cmd.idx_op = IDX_ZERO;
                if (flags.is_free)
                begin
                    if (flags.id_bad)
                    begin
                        cmd.finish = 1'b1;
                        cmd.code   = ST_NEVER;
                    end
                    else if (flags.dead)
                    begin
                        cmd.finish = 1'b1;
                        cmd.code   = ST_FREED;
                    end
                end
                else if (flags.zero)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_ZERO_SIZE;
                end
                else if (flags.bad_al)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_BAD_ALIGN;
                end
                else if (flags.ids_out)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_IDS_OUT;
                end
            end
            S_SEARCH:
            begin
                cmd.latch_b = 1'b1;
                if (!flags.in_range)
                begin
                    cmd.idx_op = IDX_LAST;
                end
                else if (!flags.fit)
                begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_HIT:
            begin
                if (flags.gap && flags.rest)
                begin
                    if (flags.full)
                    begin
                        cmd.finish = 1'b1;
                        cmd.code   = ST_TABLE_FULL;
                    end
                    else
                    begin
                        cmd.seg_op = SEG_SPLIT;
                    end
                end
                else if (flags.gap)
                begin
                    cmd.seg_op = SEG_SET_END_B;
                end
                else if (flags.rest)
                begin
                    cmd.seg_op = SEG_SET_BEGIN_BSZ;
                end
                else
                begin
                    cmd.seg_op = SEG_REMOVE;
                end
            end
            S_TAIL:
            begin
                cmd.latch_tail = 1'b1;
            end
            S_TAIL_APPLY:
            begin
                if (flags.over_cap)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_NO_CAP;
                end
                else if (flags.tail)
                begin
                    cmd.heap_upd = 1'b1;
                    cmd.seg_op   = flags.gap ? SEG_SET_END_B : SEG_REMOVE;
                end
                else if (flags.moved && flags.full)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_TABLE_FULL;
                end
                else
                begin
                    cmd.heap_upd = 1'b1;
                    cmd.seg_op   = flags.moved ? SEG_APPEND_GAP : SEG_NONE;
                end
            end
            S_RECORD:
            begin
                cmd.record   = 1'b1;
                cmd.finish   = 1'b1;
                cmd.ok_alloc = 1'b1;
                cmd.code     = ST_OK;
            end
            S_FREE_SCAN:
            begin
                if (flags.in_range && flags.scan_go)
                begin
                    cmd.idx_op = IDX_INC;
                end
                else
                begin
                    cmd.latch_left = 1'b1;
                    cmd.idx_op     = flags.left_now ? IDX_INC : IDX_HOLD;
                end
            end
            S_FREE_MERGE:
            begin
                cmd.finish = 1'b1;
                if (flags.left_reg && flags.right)
                begin
                    cmd.seg_op   = SEG_F_BOTH;
                    cmd.clr_live = 1'b1;
                end
                else if (flags.left_reg)
                begin
                    cmd.seg_op   = SEG_F_LEFT;
                    cmd.clr_live = 1'b1;
                end
                else if (flags.right)
                begin
                    cmd.seg_op   = SEG_F_RIGHT;
                    cmd.clr_live = 1'b1;
                end
                else if (flags.full)
                begin
                    cmd.code = ST_TABLE_FULL;
                end
                else
                begin
                    cmd.seg_op   = SEG_F_INSERT;
                    cmd.clr_live = 1'b1;
                end
            end
            default:
            begin
                cmd.idx_op = IDX_HOLD;
            end
        endcase
    end

endmodule

>>> rtl/ffoa_datapath.sv
module ffoa_datapath
    import ffoa_pkg::*;
#(
    parameter int FREE_SEGMENTS = FREE_SEGMENTS_DEF,
    parameter int BUFFER_IDS    = BUFFER_IDS_DEF,
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
    localparam int ID_W  = $clog2(BUFFER_IDS),
    localparam int AW    = OFFSET_BITS + 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output flags_t                 flags,
    input  logic [AW-1:0]          cap,
    input  logic                   command,
    input  logic [OFFSET_BITS-1:0] request_bytes,
    input  logic [ALIGN_W-1:0]     min_alignment,
    input  logic [ID_W-1:0]        free_id,
    output logic                   done,
    output logic [OFFSET_BITS-1:0] offset,
    output logic [ID_W-1:0]        given_id,
    output logic [2:0]             status,
    output logic [AW-1:0]          heap_end
);

    localparam int XW   = OFFSET_BITS + 2;
    localparam int SI_W = $clog2(FREE_SEGMENTS);
    localparam int CI_W = $clog2(FREE_SEGMENTS + 1);
    localparam logic [AW-1:0] LIMIT = {1'b1, {OFFSET_BITS{1'b0}}};

    // request latched at accept
    logic                   cmd_reg;
    logic [OFFSET_BITS-1:0] bytes_reg;
    logic [ALIGN_W-1:0]     align_reg;
    logic [ID_W-1:0]        fid_reg;

    logic [ALIGN_W-1:0]     al_reg;
    logic [AW-1:0]          sz_reg;
    logic [XW-1:0]          b_reg;
    logic                   tail_reg;
    logic                   left_reg;

    logic [CI_W-1:0]        idx_reg;
    logic [CI_W-1:0]        count_reg;
    logic [AW-1:0]          heap_reg;
    logic [ID_W:0]          next_id_reg;
    logic [BUFFER_IDS-1:0]  live_reg;

    logic [AW-1:0]          seg_b [FREE_SEGMENTS];
    logic [AW-1:0]          seg_e [FREE_SEGMENTS];

    logic [OFFSET_BITS-1:0] used_b [BUFFER_IDS];
    logic [AW-1:0]          used_e [BUFFER_IDS];
    logic [OFFSET_BITS-1:0] ub_q;
    logic [AW-1:0]          ue_q;

    logic                   done_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [ID_W-1:0]        given_id_reg;
    logic [2:0]             status_reg;
    logic [AW-1:0]          heap_end_reg;

    logic [SI_W-1:0]        seg_i;
    logic [SI_W-1:0]        nxt_i;
    logic [SI_W-1:0]        prv_i;
    logic [SI_W-1:0]        cnt_i;
    logic [ID_W-1:0]        rec_i;
    logic [XW-1:0]          cur_b;
    logic [XW-1:0]          cur_e;
    logic [XW-1:0]          mask_w;
    logic [XW-1:0]          sz_w;
    logic [XW-1:0]          pad_cur;
    logic [XW-1:0]          pad_heap;
    logic [XW-1:0]          b_plus_sz;
    logic [XW-1:0]          cap_lim;
    logic [ALIGN_W-1:0]     al_base;
    logic [ALIGN_W-1:0]     al_now;
    logic [XW-1:0]          al_mask_now;
    logic [XW-1:0]          sz_now;
    logic                   tail_now;

    assign seg_i = idx_reg[SI_W-1:0];
    assign nxt_i = SI_W'(idx_reg + 1'b1);
    assign prv_i = SI_W'(idx_reg - 1'b1);
    assign cnt_i = count_reg[SI_W-1:0];
    assign rec_i = next_id_reg[ID_W-1:0];

    assign cur_b = XW'(seg_b[seg_i]);
    assign cur_e = XW'(seg_e[seg_i]);

    // alignment and padded size of the request
    assign al_base     = (bytes_reg > OFFSET_BITS'(LARGE_THRESHOLD)) ? ALIGN_LARGE : ALIGN_SMALL;
    assign al_now      = (align_reg > al_base) ? align_reg : al_base;
    assign al_mask_now = XW'(al_now - 1'b1);
    assign sz_now      = (XW'(bytes_reg) + al_mask_now) & ~al_mask_now;

    assign mask_w    = XW'(al_reg - 1'b1);
    assign sz_w      = XW'(sz_reg);
    assign pad_cur   = (cur_b + mask_w) & ~mask_w;
    assign pad_heap  = (XW'(heap_reg) + mask_w) & ~mask_w;
    assign b_plus_sz = b_reg + sz_w;
    assign cap_lim   = XW'((cap > LIMIT) ? LIMIT : cap);
    assign tail_now  = (count_reg != '0) && (cur_e == XW'(heap_reg));

    always_comb
    begin
        flags          = '0;
        flags.is_free  = cmd_reg;
        flags.zero     = (bytes_reg == '0);
        flags.bad_al   = (align_reg != '0) && ((align_reg & (align_reg - 1'b1)) != '0);
        flags.ids_out  = (next_id_reg == (ID_W+1)'(BUFFER_IDS));
        flags.id_bad   = ({1'b0, fid_reg} >= next_id_reg);
        flags.dead     = !live_reg[fid_reg];
        flags.in_range = (idx_reg < count_reg);
        flags.fit      = (pad_cur <= cur_e) && ((pad_cur + sz_w) <= cur_e);
        flags.scan_go  = (cur_e < XW'(ub_q));
        flags.left_now = (idx_reg < count_reg) && (cur_e == XW'(ub_q));
        flags.left_reg = left_reg;
        flags.right    = (idx_reg < count_reg) && (cur_b == XW'(ue_q));
        flags.gap      = (b_reg != cur_b);
        flags.rest     = (cur_e > b_plus_sz);
        flags.full     = (count_reg >= CI_W'(FREE_SEGMENTS));
        flags.tail     = tail_reg;
        flags.over_cap = (b_plus_sz > cap_lim);
        flags.moved    = (b_reg != XW'(heap_reg));
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= command;
            bytes_reg <= request_bytes;
            align_reg <= min_alignment;
            fid_reg   <= free_id;
        end
        if (cmd.calc)
        begin
            al_reg <= al_now;
            sz_reg <= AW'(sz_now);
        end
        if (cmd.latch_b)
        begin
            b_reg <= pad_cur;
        end
        if (cmd.latch_tail)
        begin
            tail_reg <= tail_now;
            b_reg    <= tail_now ? pad_cur : pad_heap;
        end
        if (cmd.latch_left)
        begin
            left_reg <= (idx_reg < count_reg) && (cur_e == XW'(ub_q));
        end
    end

    // free-segment table
    always_ff @(posedge clk)
    begin
        case (cmd.seg_op)
            SEG_SPLIT:
            begin
                for (int k = 1; k < FREE_SEGMENTS; k++)
                begin
                    if (k > int'(idx_reg))
                    begin
                        seg_b[k] <= seg_b[k-1];
                        seg_e[k] <= seg_e[k-1];
                    end
                end
                seg_e[seg_i] <= AW'(b_reg);
                seg_b[nxt_i] <= AW'(b_plus_sz);
            end
            SEG_SET_END_B:
            begin
                seg_e[seg_i] <= AW'(b_reg);
            end
            SEG_SET_BEGIN_BSZ:
            begin
                seg_b[seg_i] <= AW'(b_plus_sz);
            end
            SEG_REMOVE, SEG_F_BOTH:
            begin
                for (int k = 0; k < FREE_SEGMENTS - 1; k++)
                begin
                    if (k >= int'(idx_reg))
                    begin
                        seg_b[k] <= seg_b[k+1];
                        seg_e[k] <= seg_e[k+1];
                    end
                end
                if (cmd.seg_op == SEG_F_BOTH)
                begin
                    seg_e[prv_i] <= AW'(cur_e);
                end
            end
            SEG_APPEND_GAP:
            begin
                seg_b[cnt_i] <= heap_reg;
                seg_e[cnt_i] <= AW'(b_reg);
            end
            SEG_F_LEFT:
            begin
                seg_e[prv_i] <= ue_q;
            end
            SEG_F_RIGHT:
            begin
                seg_b[seg_i] <= AW'(ub_q);
            end
            SEG_F_INSERT:
            begin
                for (int k = 1; k < FREE_SEGMENTS; k++)
                begin
                    if (k > int'(idx_reg))
                    begin
                        seg_b[k] <= seg_b[k-1];
                        seg_e[k] <= seg_e[k-1];
                    end
                end
                seg_b[seg_i] <= AW'(ub_q);
                seg_e[seg_i] <= ue_q;
            end
            default:
            begin
            end
        endcase
    end

    // buffer extents, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.record)
        begin
            used_b[rec_i] <= b_reg[OFFSET_BITS-1:0];
            used_e[rec_i] <= AW'(b_plus_sz);
        end
        ub_q <= used_b[fid_reg];
        ue_q <= used_e[fid_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            count_reg    <= '0;
            heap_reg     <= '0;
            next_id_reg  <= '0;
            live_reg     <= '0;
            done_reg     <= 1'b0;
            status_reg   <= ST_OK;
            offset_reg   <= '0;
            given_id_reg <= '0;
            heap_end_reg <= '0;
        end
        else
        begin
            case (cmd.idx_op)
                IDX_ZERO: idx_reg <= '0;
                IDX_INC:  idx_reg <= idx_reg + 1'b1;
                IDX_LAST: idx_reg <= count_reg - 1'b1;
                default:  idx_reg <= idx_reg;
            endcase

            case (cmd.seg_op)
                SEG_SPLIT, SEG_APPEND_GAP, SEG_F_INSERT:
                    count_reg <= count_reg + 1'b1;
                SEG_REMOVE, SEG_F_BOTH:
                    count_reg <= count_reg - 1'b1;
                default:
                    count_reg <= count_reg;
            endcase

            if (cmd.heap_upd)
            begin
                heap_reg <= AW'(b_plus_sz);
            end
            if (cmd.record)
            begin
                live_reg[rec_i] <= 1'b1;
                next_id_reg     <= next_id_reg + 1'b1;
            end
            if (cmd.clr_live)
            begin
                live_reg[fid_reg] <= 1'b0;
            end

            done_reg <= cmd.finish;
            if (cmd.finish)
            begin
                status_reg   <= cmd.code;
                offset_reg   <= cmd.ok_alloc ? b_reg[OFFSET_BITS-1:0] : '0;
                given_id_reg <= cmd.ok_alloc ? rec_i : '0;
                heap_end_reg <= heap_reg;
            end
        end
    end

    assign done     = done_reg;
    assign offset   = offset_reg;
    assign given_id = given_id_reg;
    assign status   = status_reg;
    assign heap_end = heap_end_reg;

endmodule

>>> rtl/first_fit_offset_allocator.sv
// Channel   Signals                                         Handshake
// request   command request_bytes min_alignment free_id     start & !busy
// result    offset given_id status heap_end                 done, one cycle
// config    psel penable pwrite paddr pwdata prdata pready  APB, capacity at 0
//
// An allocate that hits segment n runs from accept through check, search steps
// over segments 0 to n, hit, record and result; when the free-segment table
// (16 entries by default) misses, tail steps extend the heap end before the
// record. A free runs check, extent read, scan over the segments, merge and
// result. The table scan covers one segment per cycle.
// Reset clears the counters, live bits and heap end and sets the capacity to the
// full offset span; the tables need no clearing.
// The result receiver cannot stall; each result is shown for exactly one cycle.
module first_fit_offset_allocator
    import ffoa_pkg::*;
#(
    parameter int FREE_SEGMENTS = FREE_SEGMENTS_DEF,
    parameter int BUFFER_IDS    = BUFFER_IDS_DEF,
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            command,
    input  logic [OFFSET_BITS-1:0]          request_bytes,
    input  logic [ALIGN_W-1:0]              min_alignment,
    input  logic [$clog2(BUFFER_IDS)-1:0]   free_id,
    output logic                            done,
    output logic [OFFSET_BITS-1:0]          offset,
    output logic [$clog2(BUFFER_IDS)-1:0]   given_id,
    output logic [2:0]                      status,
    output logic [OFFSET_BITS:0]            heap_end,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [CFG_ADDR_W-1:0]           paddr,
    input  logic [CFG_DATA_W-1:0]           pwdata,
    output logic [CFG_DATA_W-1:0]           prdata,
    output logic                            pready
);

    localparam int AW = OFFSET_BITS + 1;

    cmd_t          cmd;
    flags_t        flags;
    logic [AW-1:0] cap_reg;
    logic          cfg_wr;

    // Capacity register: the only register, 64-bit slot at byte address 0.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= {1'b1, {OFFSET_BITS{1'b0}}};
        end
        else if (cfg_wr)
        begin
            cap_reg <= pwdata[AW-1:0];
        end
    end

    assign prdata = paddr[3] ? '0 : CFG_DATA_W'(cap_reg);

    // Controller sequences each request; datapath holds tables and arithmetic.
    ffoa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .cmd   (cmd),
        .busy  (busy)
    );

    ffoa_datapath #(
        .FREE_SEGMENTS (FREE_SEGMENTS),
        .BUFFER_IDS    (BUFFER_IDS),
        .OFFSET_BITS   (OFFSET_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .flags         (flags),
        .cap           (cap_reg),
        .command       (command),
        .request_bytes (request_bytes),
        .min_alignment (min_alignment),
        .free_id       (free_id),
        .done          (done),
        .offset        (offset),
        .given_id      (given_id),
        .status        (status),
        .heap_end      (heap_end)
    );

`ifndef SYNTHESIS
    // A result always closes a request: the block was working in the cycle before.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in flight");

    // An accepted request keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start work");

    // Failed requests report no offset and no id.
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (offset == '0 && given_id == '0))
        else $error("failed request carried an offset or id");
`endif

endmodule
